/* src/lrp_pkg.sv */
package lrp_pkg;

    localparam int FRAMES     = 16;
    localparam int PAGE_BITS  = 8;
    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_BITS  = $clog2(FRAMES + 1);
    localparam int CFG_BITS   = 5;
    localparam int CLAMP_BITS = (CFG_BITS > FILL_BITS) ? CFG_BITS : FILL_BITS;
    localparam int COUNT_BITS = 16;
    localparam int USED_BITS  = 4;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4);

    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [FILL_BITS-1:0]  t_fill;

    // recency stack update: move a frame to the top, or push a new frame
    typedef struct packed {
        logic   move;
        logic   push;
        t_frame frame;
        t_fill  fill;
    } t_stk_cmd;

endpackage

/* src/lru_page_replacement.sv */
// LRU page replacement over a fully associative frame table. Each word on the
// input channel is one page reference; each result word gives fault (miss),
// the frame now holding the page and the saturating fault count. One reference
// is taken every cycle while the output is not stalled. The page is
// registered at acceptance; one stage then does the associative compare over
// all frame tags and the recency stack shift, and writes the result register
// as soon as that register is free. A stalled result holds the input
// register, which then stalls the input channel.
// Writing i_cfg_data sets the number of frames in use (0 acts as 1, values
// above the table size act as the table size) and clears the table and the
// fault count at once; write it only while no reference is in flight.
module lru_page_replacement (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrp_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lrp_pkg::PAGE_BITS-1:0] i_page_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_fault,
    output logic [lrp_pkg::USED_BITS-1:0] o_frame_used,
    output logic [lrp_pkg::COUNT_BITS-1:0] o_fault_total
);
    import lrp_pkg::*;

    logic [CFG_BITS-1:0]   r_cfg;
    logic                  r_in_vld;
    t_page                 r_page;
    t_fill                 r_fill;
    logic [COUNT_BITS-1:0] r_faults;
    logic [COUNT_BITS-1:0] n_faults;
    logic                  r_out_vld;
    logic                  r_fault;
    logic [USED_BITS-1:0]  r_used;
    logic [COUNT_BITS-1:0] r_total;

    logic                  advance;
    logic                  cam_hit;
    t_frame                hit_frame;
    t_frame                victim;
    t_frame                frame;
    logic                  full;
    t_fill                 n_active;
    logic [CLAMP_BITS-1:0] cfg_ext;
    logic [FRAME_BITS+USED_BITS-1:0] used_ext;
    t_stk_cmd              stk_cmd;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    // effective frame count
    always_comb begin
        cfg_ext = CLAMP_BITS'(r_cfg);
        if (cfg_ext == '0) begin
            cfg_ext = CLAMP_BITS'(1);
        end else if (cfg_ext > CLAMP_BITS'(FRAMES)) begin
            cfg_ext = CLAMP_BITS'(FRAMES);
        end
        n_active = FILL_BITS'(cfg_ext);
    end

    assign full  = (r_fill >= n_active);
    assign frame = cam_hit ? hit_frame : (full ? victim : r_fill[FRAME_BITS-1:0]);

    always_comb begin
        stk_cmd.move  = advance && (cam_hit || full);
        stk_cmd.push  = advance && !cam_hit && !full;
        stk_cmd.frame = frame;
        stk_cmd.fill  = r_fill;
    end

    lrp_cam u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (i_cfg_we),
        .i_page      (r_page),
        .i_we        (advance && !cam_hit),
        .i_wr_frame  (frame),
        .o_hit       (cam_hit),
        .o_hit_frame (hit_frame)
    );

    lrp_stack u_stack (
        .i_clk    (i_clk),
        .i_cmd    (stk_cmd),
        .o_victim (victim)
    );

    assign n_faults = (!cam_hit && r_faults != '1) ? r_faults + 1'b1 : r_faults;
    assign used_ext = {{USED_BITS{1'b0}}, frame};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_page <= i_page_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_fill   <= '0;
            r_faults <= '0;
        end else if (advance) begin
            r_faults <= n_faults;
            if (stk_cmd.push) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fault <= !cam_hit;
            r_used  <= used_ext[USED_BITS-1:0];
            r_total <= n_faults;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_fault       = r_fault;
    assign o_frame_used  = r_used;
    assign o_fault_total = r_total;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= n_active)
        else $error("fill count above frames in use");

    a_hit_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cam_hit |-> r_fill != '0)
        else $error("hit on an empty table");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stk_cmd.push && !i_cfg_we) |=> r_fill == $past(r_fill) + 1'b1)
        else $error("fill count did not advance on a free frame load");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result lost after a lookup");

    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && cam_hit && !i_cfg_we) |=> r_faults == $past(r_faults))
        else $error("fault count moved on a hit");
`endif

endmodule

/* src/lrp_cam.sv */
module lrp_cam (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  lrp_pkg::t_page i_page,
    input  logic           i_we,
    input  lrp_pkg::t_frame i_wr_frame,
    output logic           o_hit,
    output lrp_pkg::t_frame o_hit_frame
);
    import lrp_pkg::*;

    logic [FRAMES-1:0] r_valid;
    t_page             r_pages [FRAMES];
    logic [FRAMES-1:0] match;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i] = r_valid[i] && (r_pages[i] == i_page);
        end
    end

    // pages are unique, so at most one frame matches
    always_comb begin
        o_hit_frame = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_hit_frame = FRAME_BITS'(i);
            end
        end
    end

    assign o_hit = |match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wr_frame] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pages[i_wr_frame] <= i_page;
        end
    end

endmodule

/* src/lrp_stack.sv */
module lrp_stack (
    input  logic              i_clk,
    input  lrp_pkg::t_stk_cmd i_cmd,
    output lrp_pkg::t_frame   o_victim
);
    import lrp_pkg::*;

    t_frame            r_order [FRAMES];
    t_frame            n_order [FRAMES];
    logic [FRAMES-1:0] match;
    t_frame            pos;
    t_fill             top;

    assign top      = i_cmd.fill - 1'b1;
    assign o_victim = r_order[0];

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i] = (r_order[i] == i_cmd.frame) && (i < int'(i_cmd.fill));
        end
    end

    always_comb begin
        pos = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                pos = FRAME_BITS'(i);
            end
        end
    end

    always_comb begin
        n_order = r_order;
        if (i_cmd.move) begin
            // close the gap at pos and drop the frame on top
            for (int i = 0; i < FRAMES; i++) begin
                if (i >= int'(pos) && i < int'(top)) begin
                    n_order[i] = r_order[(i + 1) % FRAMES];
                end else if (i == int'(top)) begin
                    n_order[i] = i_cmd.frame;
                end
            end
        end else if (i_cmd.push) begin
            n_order[i_cmd.fill[FRAME_BITS-1:0]] = i_cmd.frame;
        end
    end

    always_ff @(posedge i_clk) begin
        r_order <= n_order;
    end

endmodule

/* tb/lru_page_replacement_tb.sv */
module lru_page_replacement_tb;

    import lrp_pkg::*;

    localparam logic REF_HIT       = 1'b0;
    localparam logic REF_MISS      = 1'b1;
    localparam int   COUNT_MAX     = 65535;
    localparam int   QUIET_LIMIT   = 4000;
    localparam int   PHASES        = 14;
    localparam int   PHASE_REFS    = 110;
    localparam int   TAIL_REFS     = 150;
    localparam int   REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                  fault;
        logic [USED_BITS-1:0]  frame;
        logic [COUNT_BITS-1:0] total;
    } t_ref_word;

    typedef struct {
        t_page     page;
        bit        known;
        t_ref_word word;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_BITS-1:0]   i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PAGE_BITS-1:0]  i_page_number;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_fault;
    logic [USED_BITS-1:0]  o_frame_used;
    logic [COUNT_BITS-1:0] o_fault_total;

    // frame table model
    t_page               page_tag [FRAMES];
    bit                  tag_live [FRAMES];
    int                  recency  [FRAMES];
    int                  loaded;
    int                  faults_seen;
    logic [CFG_BITS-1:0] frames_cfg;

    t_ref_word pending_words[$];
    bit        row_known;
    t_ref_word row_word;
    bit        idling_on;
    int        stall_left;
    int        errors;
    int        quiet_cycles;

    // after reset: four frames, empty table
    t_dir_row directed_rows [16] = '{
        '{8'h00, 1'b1, '{REF_MISS, 4'd0, 16'd1}},
        '{8'hFF, 1'b1, '{REF_MISS, 4'd1, 16'd2}},
        '{8'h00, 1'b1, '{REF_HIT,  4'd0, 16'd2}},
        '{8'h80, 1'b1, '{REF_MISS, 4'd2, 16'd3}},
        '{8'h01, 1'b1, '{REF_MISS, 4'd3, 16'd4}},
        '{8'h07, 1'b1, '{REF_MISS, 4'd1, 16'd5}},
        '{8'hFF, 1'b1, '{REF_MISS, 4'd0, 16'd6}},
        '{8'h07, 1'b1, '{REF_HIT,  4'd1, 16'd6}},
        '{8'h80, 1'b1, '{REF_HIT,  4'd2, 16'd6}},
        '{8'h7F, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0}
    };

    lru_page_replacement uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_page_number (i_page_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_fault       (o_fault),
        .o_frame_used  (o_frame_used),
        .o_fault_total (o_fault_total)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_frame_table();
        for (int i = 0; i < FRAMES; i++) begin
            page_tag[i] = '0;
            tag_live[i] = 1'b0;
            recency[i]  = 0;
        end
        loaded      = 0;
        faults_seen = 0;
    endfunction

    // move the stack entry at pos to the most recent place
    function automatic void promote_to_recent(input int pos);
        int top;
        int moved;
        if (loaded == 0 || pos >= loaded)
            return;
        top   = loaded - 1;
        moved = recency[pos];
        for (int i = pos; i < top; i++)
            recency[i] = recency[i + 1];
        recency[top] = moved;
    endfunction

    function automatic t_ref_word lru_predict(input t_page page);
        int        n;
        int        pos;
        int        frame;
        bit        hit;
        t_ref_word r;
        if (frames_cfg == 0)
            n = 1;
        else if (frames_cfg > FRAMES)
            n = FRAMES;
        else
            n = int'(frames_cfg);
        if (loaded > n)
            loaded = n;
        hit   = 1'b0;
        frame = 0;
        for (int i = 0; i < n; i++) begin
            if (!hit && tag_live[i] && page_tag[i] == page) begin
                hit   = 1'b1;
                frame = i;
            end
        end
        if (hit) begin
            pos = loaded;
            for (int i = 0; i < loaded; i++)
                if (pos == loaded && recency[i] == frame)
                    pos = i;
            promote_to_recent(pos);
        end else begin
            if (loaded < n) begin
                frame           = loaded;
                recency[loaded] = frame;
                loaded++;
            end else begin
                frame = recency[0] % FRAMES;
                promote_to_recent(0);
            end
            page_tag[frame] = page;
            tag_live[frame] = 1'b1;
            if (faults_seen < COUNT_MAX)
                faults_seen++;
        end
        r.fault = hit ? REF_HIT : REF_MISS;
        r.frame = USED_BITS'(frame);
        r.total = COUNT_BITS'(faults_seen);
        return r;
    endfunction

    // model update, result check and watchdog, all on the rising edge
    always @(posedge i_clk) begin
        t_ref_word got;
        t_ref_word want;
        bit        moved;
        if (!i_rst_n) begin
            frames_cfg = CFG_RESET;
            clear_frame_table();
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) begin
                frames_cfg = i_cfg_data;
                clear_frame_table();
            end
            if (i_in_valid && !o_in_stall) begin
                want = lru_predict(i_page_number);
                if (row_known)
                    want = row_word;
                pending_words.push_back(want);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got   = '{o_fault, o_frame_used, o_fault_total};
                if (pending_words.size() == 0) begin
                    if (errors < REPORT_LIMIT)
                        $display("unexpected result word: fault=%0d frame=%0d total=%0d",
                                 got.fault, got.frame, got.total);
                    errors++;
                end else begin
                    want = pending_words.pop_front();
                    if (got !== want) begin
                        if (errors < REPORT_LIMIT) begin
                            $write("mismatch: exp fault=%0d frame=%0d total=%0d, ",
                                   want.fault, want.frame, want.total);
                            $display("got fault=%0d frame=%0d total=%0d",
                                     got.fault, got.frame, got.total);
                        end
                        errors++;
                    end
                end
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("lru_page_replacement regression: fail");
                $finish;
            end
        end
    end

    // output back-pressure in random bursts, only while idling is on
    always @(negedge i_clk) begin
        if (!idling_on) begin
            stall_left  = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_ref(input t_page page, input bit known, input t_ref_word typed);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        row_known     = known;
        row_word      = typed;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
    endtask

    // write only with nothing in flight
    task automatic write_frames(input logic [CFG_BITS-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int                  phase_frames [10];
        logic [CFG_BITS-1:0] setting;
        int                  n;
        int                  span;
        t_page               base;
        t_page               page;
        t_page               last_page;

        phase_frames  = '{0, 31, 16, 1, 17, 2, 5, 8, 15, 3};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_page_number = '0;
        i_out_stall   = 1'b0;
        row_known     = 1'b0;
        row_word      = '0;
        idling_on     = 1'b1;
        stall_left    = 0;
        errors        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_ref(directed_rows[r].page, directed_rows[r].known, directed_rows[r].word);

        for (int p = 0; p < PHASES; p++) begin
            setting = (p < 10) ? CFG_BITS'(phase_frames[p]) : CFG_BITS'($urandom_range(0, 31));
            write_frames(setting);
            idling_on = (p % 4 != 3);
            if (setting == 0)
                n = 1;
            else if (setting > FRAMES)
                n = FRAMES;
            else
                n = int'(setting);
            // working set from the table size to a little over twice it: hits and evictions both
            base = t_page'($urandom_range(0, 255));
            span = n + $urandom_range(0, n + 2);
            for (int k = 0; k < PHASE_REFS; k++) begin
                if ($urandom_range(0, 99) < 85)
                    page = base + t_page'($urandom_range(0, span - 1));
                else
                    page = t_page'($urandom_range(0, 255));
                send_ref(page, 1'b0, '0);
            end
        end

        // single frame, no idling: nearly every reference misses
        write_frames(CFG_BITS'(1));
        idling_on = 1'b0;
        last_page = '0;
        for (int k = 0; k < TAIL_REFS; k++) begin
            if ($urandom_range(0, 19) == 0)
                page = last_page;
            else
                page = last_page ^ t_page'($urandom_range(1, 255));
            send_ref(page, 1'b0, '0);
            last_page = page;
        end

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("lru_page_replacement regression: pass");
        else
            $display("lru_page_replacement regression: fail");
        $finish;
    end

endmodule
